FILE: hw/rtl/dtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtl_pkg: shared types and constants for the device table
// Table geometry, the search request passed along the cell chain, and the
// write request broadcast back to the cells.
// ----------------------------------------------------------------------------
package dtl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W  = 48;
  localparam int STR_W   = 8;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 4;
  localparam int USE_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  // Search request moving one cell per cycle
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  addr;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] min_count;
    logic [IDX_W-1:0]   min_idx;
  } token_t;

  // Entry update broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]  addr;
    logic [STR_W-1:0]   strength;
    logic [COUNT_W-1:0] count;
  } wr_t;

  // Entry index as reported on the slot field (modulo 16)
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

  // Fill level as reported on the entries field (modulo 32)
  function automatic logic [USE_W-1:0] use_of(input logic [FILL_W-1:0] fill);
    logic [31:0] wide;
    wide = 32'(fill);
    return wide[USE_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/device_table_lfu_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_table_lfu_update: device table with least-frequently-used replacement
// Search path: one register per cell of the search chain, the first loaded
// as the request is accepted, then a capture of the finished search, then
// the table update and the result register.
// A new request is taken only once the previous one is finished, which a
// stalled result holds off; the chain carries one search at a time and the
// table update must land before the next.
// Reset clears the fill level and all handshake state; entry contents are
// left as they are, and a hit is only taken below the fill level.
// ----------------------------------------------------------------------------
module device_table_lfu_update (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dtl_pkg::ADDR_W-1:0]  device_address,
  input  logic signed [dtl_pkg::STR_W-1:0] signal_strength,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        was_known,
  output logic [dtl_pkg::SLOT_W-1:0]  slot,
  output logic [dtl_pkg::COUNT_W-1:0] occurrence_count,
  output logic                        evicted,
  output logic [dtl_pkg::USE_W-1:0]   entries_in_use
);
  import dtl_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [FILL_W-1:0]  fill_level;
  logic [FILL_W-1:0]  fill_level_next;
  logic [STR_W-1:0]   req_strength;
  token_t             pend;
  token_t             chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] filled;
  wr_t                wr;
  logic               accept;
  logic               finish;
  logic               out_free;
  logic [IDX_W-1:0]   where;
  logic [COUNT_W-1:0] new_count;
  logic               new_evict;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Search request injected at the head of the chain
  always_comb begin
    chain[0].valid     = accept;
    chain[0].addr      = device_address;
    chain[0].hit       = 1'b0;
    chain[0].hit_idx   = '0;
    chain[0].hit_count = '0;
    chain[0].min_count = COUNT_MAX;
    chain[0].min_idx   = '0;
  end

  // Cell chain
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign filled[i] = (FILL_W'(i) < fill_level);
    dtl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(i)),
      .filled   (filled[i]),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1]),
      .wr       (wr)
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SEARCH;
      S_SEARCH: if (chain[TABLE_ENTRIES].valid) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    finish   = 1'b0;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_SEARCH: in_stall = 1'b1;
      S_FINISH: finish   = out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  // Placement decision from the finished search
  always_comb begin
    fill_level_next = fill_level;
    new_evict       = 1'b0;
    new_count       = COUNT_ONE;
    if (pend.hit) begin
      where     = pend.hit_idx;
      new_count = pend.hit_count;
    end else if (fill_level == FILL_W'(TABLE_ENTRIES)) begin
      where     = pend.min_idx;
      new_evict = 1'b1;
    end else begin
      where           = IDX_W'(fill_level);
      fill_level_next = FILL_W'(fill_level + 1'b1);
    end
  end

  // Update broadcast to the cells
  always_comb begin
    wr.en       = finish;
    wr.idx      = where;
    wr.addr     = pend.addr;
    wr.strength = req_strength;
    wr.count    = new_count;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_level <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        fill_level <= fill_level_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and search capture, result register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_strength <= signal_strength;
    end
    if (chain[TABLE_ENTRIES].valid) begin
      pend <= chain[TABLE_ENTRIES];
    end
    if (finish) begin
      was_known        <= pend.hit;
      slot             <= slot_of(where);
      occurrence_count <= new_count;
      evicted          <= new_evict;
      entries_in_use   <= use_of(fill_level_next);
    end
  end

  // Checks
  a_chain_only_searching: assert property (@(posedge clk) disable iff (rst)
    chain[TABLE_ENTRIES].valid |-> state == S_SEARCH)
    else $error("search left the chain outside of a search");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SEARCH)
    else $error("accepted request did not start a search");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(TABLE_ENTRIES))
    else $error("fill level beyond table size");

  a_new_entry_count: assert property (@(posedge clk) disable iff (rst)
    finish && !pend.hit |-> new_count == COUNT_ONE)
    else $error("new entry placed with count other than one");

  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    finish && new_evict |-> fill_level == FILL_W'(TABLE_ENTRIES))
    else $error("eviction while table has room");

endmodule

FILE: hw/rtl/dtl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtl_cell: one table entry of the device table
// Holds address, strength and count of one entry. Compares the passing
// search request against its entry, folds in the hit and the running
// minimum count, and registers the request toward the next cell.
// ----------------------------------------------------------------------------
module dtl_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [dtl_pkg::IDX_W-1:0] cell_idx,
  input  logic                      filled,
  input  dtl_pkg::token_t           tok_in,
  output dtl_pkg::token_t           tok_out,
  input  dtl_pkg::wr_t              wr
);
  import dtl_pkg::*;

  logic [ADDR_W-1:0]  entry_addr;
  logic [STR_W-1:0]   entry_strength;
  logic [COUNT_W-1:0] entry_count;
  token_t             tok_next;

  // Entry storage, written by the broadcast update
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == cell_idx) begin
      entry_addr     <= wr.addr;
      entry_strength <= wr.strength;
      entry_count    <= wr.count;
    end
  end

  // Compare and fold into the passing request
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && filled && entry_addr == tok_in.addr) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_idx   = cell_idx;
      tok_next.hit_count = (entry_count == COUNT_MAX) ? entry_count
                                                      : entry_count + COUNT_ONE;
    end
    // strict compare keeps the lowest index on a tie
    if (entry_count < tok_in.min_count) begin
      tok_next.min_count = entry_count;
      tok_next.min_idx   = cell_idx;
    end
  end

  // Hand off to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.addr      <= tok_next.addr;
    tok_out.hit       <= tok_next.hit;
    tok_out.hit_idx   <= tok_next.hit_idx;
    tok_out.hit_count <= tok_next.hit_count;
    tok_out.min_count <= tok_next.min_count;
    tok_out.min_idx   <= tok_next.min_idx;
  end

endmodule
